// ----- hdl/dalp_pkg.sv -----
// Shared constants and types for the decimating A-law packetizer.
// Used by dalp_alaw_enc and decimating_alaw_packetizer; no dependencies.
`default_nettype none

package dalp_pkg;

  // default maximum packet size in bytes
  localparam int MAX_PACKET_DEF = 2048;

  // register reset values
  localparam logic [11:0] PKT_LEN_RST = 12'd512;
  localparam logic [3:0]  DEC_RST     = 4'd6;

  // A-law encoding constants
  localparam logic [15:0] SAT_MAG   = 16'd32635;
  localparam logic        SIGN_NEG  = 1'b1;     // sign bit 0x80 for negative values
  localparam logic [7:0]  XOR_MASK  = 8'hD5;
  localparam logic [3:0]  SEG0_SHIFT = 4'd4;
  localparam logic [3:0]  SEG_SHIFT_OFS = 4'd3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PKT_LEN = 1'b0,
    REG_DEC     = 1'b1
  } reg_idx_t;

  // one audio sample
  typedef logic signed [15:0] sample_t;

endpackage

`default_nettype wire

// ----- hdl/dalp_alaw_enc.sv -----
// Stereo to mono averaging and A-law encoding of one sample pair.
// Depends on dalp_pkg; purely combinational.
`default_nettype none

module dalp_alaw_enc
  import dalp_pkg::*;
(
  input  sample_t     left,
  input  sample_t     right,
  output logic [7:0]  code
);

  logic signed [16:0] sum;
  logic signed [16:0] adj;
  logic signed [16:0] half;
  logic [16:0]        mag_raw;
  logic [14:0]        mag;
  logic [2:0]         seg;
  logic [3:0]         shamt;
  logic [3:0]         mant;

  // average to mono, truncating toward zero
  always_comb begin
    sum  = {left[15], left} + {right[15], right};
    adj  = sum + 17'(sum[16]);
    half = $signed(adj) >>> 1;
  end

  // magnitude with saturation, most negative value included
  always_comb begin
    mag_raw = half[16] ? 17'(-half) : 17'(half);
    if (mag_raw > 17'(SAT_MAG)) begin
      mag = SAT_MAG[14:0];
    end else begin
      mag = mag_raw[14:0];
    end
  end

  // segment from highest set bit among bits 14..8
  always_comb begin
    if (mag[14])      seg = 3'd7;
    else if (mag[13]) seg = 3'd6;
    else if (mag[12]) seg = 3'd5;
    else if (mag[11]) seg = 3'd4;
    else if (mag[10]) seg = 3'd3;
    else if (mag[9])  seg = 3'd2;
    else if (mag[8])  seg = 3'd1;
    else              seg = 3'd0;
  end

  // mantissa and final code
  always_comb begin
    shamt = (seg == 3'd0) ? SEG0_SHIFT : (4'(seg) + SEG_SHIFT_OFS);
    mant  = 4'(mag >> shamt);
    code  = {(half[16] ? SIGN_NEG : 1'b0), seg, mant} ^ XOR_MASK;
  end

endmodule

`default_nettype wire

// ----- hdl/decimating_alaw_packetizer.sv -----
// Top level of the decimating A-law packetizer: config registers, counters, pipeline.
// Depends on dalp_pkg and dalp_alaw_enc.
`default_nettype none

// Takes one stereo sample pair per cycle on the sample channel, while
// sample_stall is low, and keeps the first pair of every decimation_factor
// pairs. Each kept pair is averaged to mono, A-law encoded and delivered on
// the code channel with its position in the payload and a flag on the byte
// that completes a packet of packet_length bytes. Throughput is one pair per
// clock unless the code channel stalls; a kept pair passes the input register,
// then the result register, before its code is presented, and the code
// channel's stall holds back the sample channel only when both stages are full.
// Registers: packet_length at byte address 0, decimation_factor at byte
// address 4, both readable; write them only while the block is idle.

module decimating_alaw_packetizer
  import dalp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  localparam int POS_W = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // sample channel
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           left_in,
  input  sample_t           right_in,
  // code channel
  output logic              code_valid,
  input  logic              code_stall,
  output logic [7:0]        code_byte,
  output logic [POS_W-1:0]  payload_pos,
  output logic              packet_last
);

  localparam int CMP_W = (POS_W + 1 > 13) ? POS_W + 1 : 13;

  logic [11:0]      pkt_len;
  logic [3:0]       dec_factor;
  logic [3:0]       phase_count;
  logic [3:0]       phase_count_next;
  logic [POS_W-1:0] fill_index;
  logic [POS_W-1:0] fill_index_next;
  logic [CMP_W-1:0] len_eff;
  logic [4:0]       factor_eff;
  logic             last_now;
  logic             acc;
  logic             s1_free;
  logic             s2_load;
  logic             s1_valid;
  sample_t          s1_left;
  sample_t          s1_right;
  logic [POS_W-1:0] s1_pos;
  logic             s1_last;
  logic [7:0]       enc_code;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_len    <= PKT_LEN_RST;
      dec_factor <= DEC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PKT_LEN: pkt_len    <= pwdata[11:0];
        REG_DEC:     dec_factor <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PKT_LEN: prdata = 32'(pkt_len);
      REG_DEC:     prdata = 32'(dec_factor);
      default:     prdata = '0;
    endcase
  end

  // handshake between the stages
  assign s2_load      = !code_valid || !code_stall;
  assign s1_free      = !s1_valid || s2_load;
  assign sample_stall = !s1_free;
  assign acc          = sample_valid && s1_free;

  // effective packet length and decimation factor
  always_comb begin
    if (pkt_len == 12'd0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(pkt_len) > CMP_W'(MAX_PACKET)) begin
      len_eff = CMP_W'(MAX_PACKET);
    end else begin
      len_eff = CMP_W'(pkt_len);
    end
    factor_eff = (dec_factor == 4'd0) ? 5'd1 : 5'(dec_factor);
  end

  // next counter values
  always_comb begin
    last_now         = (CMP_W'(fill_index) + CMP_W'(1)) >= len_eff;
    fill_index_next  = last_now ? '0 : fill_index + POS_W'(1);
    phase_count_next = ((5'(phase_count) + 5'd1) >= factor_eff) ? 4'd0
                                                                : phase_count + 4'd1;
  end

  // decimation phase and packet fill counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      fill_index  <= '0;
    end else if (acc) begin
      phase_count <= phase_count_next;
      if (phase_count == 4'd0) begin
        fill_index <= fill_index_next;
      end
    end
  end

  // input register: kept pairs only
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= sample_valid && (phase_count == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_left  <= left_in;
      s1_right <= right_in;
      s1_pos   <= fill_index;
      s1_last  <= last_now;
    end
  end

  dalp_alaw_enc u_enc (
    .left  (s1_left),
    .right (s1_right),
    .code  (enc_code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (s2_load) begin
      code_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      code_byte   <= enc_code;
      payload_pos <= s1_pos;
      packet_last <= s1_last;
    end
  end

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !code_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_keep_phase: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid == ($past(phase_count) == 4'd0))
    else $error("kept pair does not match decimation phase");

  a_last_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && (phase_count == 4'd0) && last_now |=> fill_index == '0)
    else $error("fill index not cleared after last byte");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_pos))
    else $error("input register overwritten while output stalled");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for decimating_alaw_packetizer: sample pairs in, A-law codes out.
// Depends on dalp_pkg and the packetizer RTL; predicts each code transfer and checks it in order.

module tb
  import dalp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS    = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 4;
  localparam int BATCH_ITEMS = 125;

  typedef struct packed {
    sample_t l_smp;
    sample_t r_smp;
  } stereo_pair_t;

  typedef struct packed {
    logic [7:0]          code;
    logic [POS_BITS-1:0] pos;
    logic                last;
  } alaw_byte_t;

  // clock, reset and block ports
  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  sample_t             left_in = '0;
  sample_t             right_in = '0;
  logic                code_valid;
  logic                code_stall = 1'b0;
  logic [7:0]          code_byte;
  logic [POS_BITS-1:0] payload_pos;
  logic                packet_last;

  // stimulus and prediction state
  stereo_pair_t pairs_pending[$];
  alaw_byte_t   codes_due[$];
  logic [11:0]  pkt_len_cfg = PKT_LEN_RST;
  logic [3:0]   dec_cfg = DEC_RST;
  int           phase_cnt = 0;
  int           fill_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         pair_taken = 1'b0;
  logic         hold_req = 1'b0;
  logic         hold_ack = 1'b0;
  int           hold_left = 0;
  int           mismatches = 0;
  int           cycles = 0;

  decimating_alaw_packetizer dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .left_in      (left_in),
    .right_in     (right_in),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_byte    (code_byte),
    .payload_pos  (payload_pos),
    .packet_last  (packet_last)
  );

  // A-law code of one mono value, sign and xor mask applied
  function automatic logic [7:0] alaw_code(int mono);
    logic    neg;
    int      mag;
    int      seg;
    int      b;
    int      sh;
    logic [3:0] mant;
    neg = (mono < 0);
    mag = neg ? -mono : mono;
    if (mag > int'(SAT_MAG)) mag = int'(SAT_MAG);
    seg = 0;
    for (b = 7; b >= 1; b--) begin
      if (seg == 0 && mag[b + 7]) seg = b;
    end
    sh = (seg == 0) ? int'(SEG0_SHIFT) : seg + int'(SEG_SHIFT_OFS);
    mant = 4'((mag >> sh) & 'h0f);
    return {(neg ? SIGN_NEG : 1'b0), 3'(seg), mant} ^ XOR_MASK;
  endfunction

  // advance the decimation and packet counters for one accepted pair
  task automatic predict_pair(sample_t l_smp, sample_t r_smp);
    int         factor;
    int         len;
    int         mono;
    alaw_byte_t nxt;
    factor = (dec_cfg == 0) ? 1 : int'(dec_cfg);
    len = (pkt_len_cfg == 0) ? 1 : int'(pkt_len_cfg);
    if (len > MAX_PACKET_DEF) len = MAX_PACKET_DEF;
    if (phase_cnt == 0) begin
      mono = (int'(l_smp) + int'(r_smp)) / 2;
      nxt.code = alaw_code(mono);
      nxt.pos = POS_BITS'(fill_cnt);
      nxt.last = (fill_cnt + 1 >= len);
      codes_due.push_back(nxt);
      fill_cnt = nxt.last ? 0 : ((fill_cnt + 1) & 'h7ff);
    end
    phase_cnt = (phase_cnt + 1 >= factor) ? 0 : ((phase_cnt + 1) & 'hf);
  endtask

  // random pair, weighted towards extremes and segment edges
  function automatic stereo_pair_t rand_pair();
    stereo_pair_t p;
    int           pick;
    int           v;
    pick = $urandom_range(99);
    p.l_smp = sample_t'($urandom);
    p.r_smp = sample_t'($urandom);
    if (pick < 10) begin
      p.l_smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      p.r_smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end else if (pick < 25) begin
      v = (1 << $urandom_range(14)) + $urandom_range(2) - 1;
      if ($urandom_range(1)) v = -v;
      p.l_smp = sample_t'(v);
      p.r_smp = sample_t'(v);
    end else if (pick < 32) begin
      v = 32630 + $urandom_range(10);
      if ($urandom_range(1)) v = -v;
      p.l_smp = sample_t'(v);
      p.r_smp = sample_t'(v);
    end
    return p;
  endfunction

  task automatic queue_pair(int l_val, int r_val);
    stereo_pair_t p;
    p.l_smp = sample_t'(l_val);
    p.r_smp = sample_t'(r_val);
    pairs_pending.push_back(p);
  endtask

  task automatic queue_random(int n);
    repeat (n) pairs_pending.push_back(rand_pair());
  endtask

  // block until every pair is taken and every code has come out
  task automatic drain();
    while (pairs_pending.size() != 0 || sample_valid || codes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_PKT_LEN) pkt_len_cfg = val[11:0];
    else dec_cfg = val[3:0];
  endtask

  task automatic configure(logic [31:0] len, logic [31:0] dec);
    write_reg(REG_PKT_LEN, len);
    write_reg(REG_DEC, dec);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // sample driver: new pair only when the channel is empty or the last one transferred
  always @(negedge clk) begin : drive_pairs
    stereo_pair_t nxt;
    if (!sample_valid || pair_taken) begin
      if (!rst && pairs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pairs_pending.pop_front();
        left_in <= nxt.l_smp;
        right_in <= nxt.r_smp;
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // code receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      code_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      code_stall <= 1'b1;
    end else begin
      code_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: predict on each sample transfer, check each code transfer
  always @(posedge clk) begin : check_codes
    alaw_byte_t want;
    if (rst) begin
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) predict_pair(left_in, right_in);
      if (code_valid && !code_stall) begin
        if (codes_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected code transfer: code %h pos %0d last %b",
                     code_byte, payload_pos, packet_last);
          mismatches++;
        end else begin
          want = codes_due.pop_front();
          if (code_byte !== want.code || payload_pos !== want.pos ||
              packet_last !== want.last) begin
            if (mismatches < 10)
              $display("code mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       want.code, want.pos, want.last,
                       code_byte, payload_pos, packet_last);
            mismatches++;
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    int seg_vals[14] = '{0, 15, 16, 255, 256, 511, 1024, 2048, 4096, 8192,
                         16384, 32635, 32636, -4096};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, rounding toward zero, every segment but segment 2
    configure(4, 1);
    queue_pair(32767, 32767);
    queue_pair(-32768, -32768);
    queue_pair(32767, -32768);
    queue_pair(-1, 0);
    queue_pair(-3, 0);
    queue_pair(-32767, -32767);
    foreach (seg_vals[i]) queue_pair(seg_vals[i], seg_vals[i]);
    drain();

    // directed: factor lowered part way through a decimation cycle
    configure(4, 15);
    queue_pair(100, -300);
    queue_pair(1, 2);
    queue_pair(3, 4);
    drain();
    write_reg(REG_DEC, 2);
    queue_pair(-20000, 5000);
    queue_pair(7, 7);
    drain();

    // random batches over several settings and idling patterns
    send_idle_pct = 35;
    recv_idle_pct = 49;
    configure(1, 1);
    queue_random(BATCH_ITEMS);
    drain();
    configure(2048, 15);
    queue_random(BATCH_ITEMS);
    drain();

    send_idle_pct = 49;
    recv_idle_pct = 35;
    configure(0, 0);
    queue_random(BATCH_ITEMS);
    drain();
    configure(4095, 2);
    queue_random(BATCH_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure($urandom_range(64, 1), $urandom_range(15, 1));
    queue_random(BATCH_ITEMS);
    drain();

    // receiver holds off while pairs keep coming, so the input stalls
    configure(5, 1);
    hold_req = ~hold_req;
    queue_random(BATCH_ITEMS);
    drain();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dalp_pkg.sv
hdl/dalp_alaw_enc.sv
hdl/decimating_alaw_packetizer.sv
tb/tb.sv
